// File: rtl/clt_pkg.sv
// Package for the command line tokenizer: character codes, field widths,
// default sizes and the parse state type. No dependencies.
package clt_pkg;

	localparam int LINE_BYTES_DEF = 64;
	localparam int ARGS_MAX_DEF   = 16;

	localparam int BYTE_W  = 8;
	localparam int POS_W   = 6;
	localparam int INDEX_W = 5;

	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;

	typedef enum logic [2:0] {
		PS_IDLE = 3'b001,
		PS_WORD = 3'b010,
		PS_GAP  = 3'b100
	} parse_state_t;

endpackage

// File: rtl/clt_byte_if.sv
// Console byte channel of the command line tokenizer.
// Depends on clt_pkg for the byte width.
interface clt_byte_if
	import clt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/clt_token_if.sv
// Result channel of the command line tokenizer: echo, line store write,
// argument mark and end of line report. Depends on clt_pkg for widths.
interface clt_token_if
	import clt_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  echo_byte;
	logic               store_valid;
	logic [POS_W-1:0]   store_pos;
	logic [BYTE_W-1:0]  store_byte;
	logic               token_start;
	logic [INDEX_W-1:0] arg_index;
	logic               line_end;
	logic               line_full;
	logic [INDEX_W-1:0] arg_count;
	logic [POS_W-1:0]   line_length;

	modport source (output valid, output echo_byte, output store_valid, output store_pos,
		output store_byte, output token_start, output arg_index, output line_end,
		output line_full, output arg_count, output line_length, input ready);
	modport sink (input valid, input echo_byte, input store_valid, input store_pos,
		input store_byte, input token_start, input arg_index, input line_end,
		input line_full, input arg_count, input line_length, output ready);
endinterface

// File: rtl/command_line_tokenizer.sv
// Command line tokenizer top level: input register, parse logic and result register.
// Depends on clt_pkg, clt_byte_if and clt_token_if.
//
//  channel   modport  payload                              beats
//  console   sink     rx_byte                              one per received byte
//  token     source   echo, store write, mark, line report zero or one per byte
//
// A byte is accepted every cycle unless token stalls; it is held in the input register.
// The parse state and the result register are updated in the same cycle from the
// input register, so a byte can follow the previous one in the next cycle.
// Control bytes are consumed from the input register without a result beat.
// A stall on token holds the result register and, behind it, any non-control input byte.
// arst_n clears the parse state, the counters and both valid flags.
module command_line_tokenizer
	import clt_pkg::*;
#(
	parameter int LINE_BYTES = LINE_BYTES_DEF,
	parameter int ARGS_MAX   = ARGS_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	clt_byte_if.sink          console,
	clt_token_if.source       token
);

	localparam int PW = $clog2(LINE_BYTES);
	localparam int AW = $clog2(ARGS_MAX + 1);
	localparam logic [PW-1:0] POS_LAST = PW'(LINE_BYTES - 1);
	localparam logic [AW-1:0] ARG_TOP  = AW'(ARGS_MAX);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	parse_state_t      state_q, state_d;
	logic [AW-1:0]     arg_q, arg_d;
	logic [PW-1:0]     wpos_q, wpos_d;

	logic              out_valid_q;
	logic              drop, advance, full, is_cr, is_space;
	logic [AW-1:0]     arg_inc, arg_done;
	logic [AW+INDEX_W-1:0] arg_wide, cnt_wide;
	logic [PW+POS_W-1:0]   pos_wide;

	logic               sv, ts, le, lf;
	logic [BYTE_W-1:0]  sb;

	assign is_cr    = (byte_s1 == CH_CR);
	assign is_space = (byte_s1 == CH_SPACE);
	// Bytes below space and bytes with the top bit set count as control, except CR.
	assign drop     = ((byte_s1 < CH_SPACE) || byte_s1[BYTE_W-1]) && !is_cr;
	assign full     = (wpos_q == POS_LAST);
	assign advance  = valid_s1 && (drop || !out_valid_q || token.ready);

	assign console.ready = !valid_s1 || advance;

	assign arg_inc  = (arg_q < ARG_TOP) ? arg_q + AW'(1) : ARG_TOP;
	assign arg_done = (state_q == PS_WORD) ? arg_inc : arg_q;

	always_comb begin
		state_d = state_q;
		arg_d   = arg_q;
		wpos_d  = wpos_q;
		sv = 1'b0;
		sb = CH_NUL;
		ts = 1'b0;
		le = 1'b0;
		lf = 1'b0;
		if (full || is_cr) begin
			sv = 1'b1;
			le = 1'b1;
			lf = full;
			state_d = PS_IDLE;
			arg_d   = '0;
			wpos_d  = '0;
		end else if (state_q == PS_WORD) begin
			if (is_space) begin
				state_d = PS_GAP;
				arg_d   = arg_inc;
			end
			sv = 1'b1;
			sb = byte_s1;
			wpos_d = wpos_q + PW'(1);
		end else if (!is_space) begin
			ts = 1'b1;
			state_d = PS_WORD;
			sv = 1'b1;
			sb = byte_s1;
			wpos_d = wpos_q + PW'(1);
		end
	end

	// Zero-extend before masking so narrow counters still fill the fixed fields.
	assign arg_wide = {{INDEX_W{1'b0}}, arg_q};
	assign cnt_wide = {{INDEX_W{1'b0}}, arg_done};
	assign pos_wide = {{POS_W{1'b0}}, wpos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (console.ready) begin
			valid_s1 <= console.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (console.ready && console.valid) begin
			byte_s1 <= console.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_IDLE;
			arg_q   <= '0;
			wpos_q  <= '0;
		end else if (advance && !drop) begin
			state_q <= state_d;
			arg_q   <= arg_d;
			wpos_q  <= wpos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && !drop) begin
			out_valid_q <= 1'b1;
		end else if (token.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !drop) begin
			token.echo_byte   <= byte_s1;
			token.store_valid <= sv;
			token.store_pos   <= sv ? pos_wide[POS_W-1:0] : '0;
			token.store_byte  <= sb;
			token.token_start <= ts;
			token.arg_index   <= ts ? arg_wide[INDEX_W-1:0] : '0;
			token.line_end    <= le;
			token.line_full   <= lf;
			token.arg_count   <= le ? cnt_wide[INDEX_W-1:0] : '0;
			token.line_length <= le ? pos_wide[POS_W-1:0] : '0;
		end
	end

	assign token.valid = out_valid_q;

	a_wpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= POS_LAST)
		else $error("write position beyond the last store slot");

	a_arg_range: assert property (@(posedge clk) disable iff (!arst_n)
		arg_q <= ARG_TOP)
		else $error("argument counter above its saturation value");

	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !drop && (full || is_cr)) |=>
			(wpos_q == '0 && arg_q == '0 && state_q == PS_IDLE))
		else $error("parse state not cleared after end of line");

	a_end_term: assert property (@(posedge clk) disable iff (!arst_n)
		(token.valid && token.line_end) |->
			(token.store_valid && token.store_byte == CH_NUL &&
			 token.store_pos == token.line_length))
		else $error("end of line beat without terminator write");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !token.ready) |=> (out_valid_q && $stable(token.echo_byte)))
		else $error("result register overwritten while stalled");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Testbench for command_line_tokenizer: random console traffic is checked against a
// byte-level line parser model kept here. Depends on clt_pkg, clt_byte_if, clt_token_if.
module testbench
	import clt_pkg::*;
();

	localparam int LINE_BYTES = LINE_BYTES_DEF;
	localparam int ARGS_MAX   = ARGS_MAX_DEF;

	typedef struct packed {
		logic [BYTE_W-1:0]  echo_byte;
		logic               store_valid;
		logic [POS_W-1:0]   store_pos;
		logic [BYTE_W-1:0]  store_byte;
		logic               token_start;
		logic [INDEX_W-1:0] arg_index;
		logic               line_end;
		logic               line_full;
		logic [INDEX_W-1:0] arg_count;
		logic [POS_W-1:0]   line_length;
	} token_beat_t;

	logic clk;
	logic arst_n;

	clt_byte_if  console_ch ();
	clt_token_if token_ch ();

	command_line_tokenizer #(
		.LINE_BYTES (LINE_BYTES),
		.ARGS_MAX   (ARGS_MAX)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.console (console_ch),
		.token   (token_ch)
	);

	// Line parser state, mirrored from the accepted byte stream.
	parse_state_t parse_mode = PS_IDLE;
	int           word_count = 0;
	int           line_fill  = 0;

	logic [BYTE_W-1:0] rx_bytes[$];
	token_beat_t       pending_results[$];

	int   items_queued = 0;
	int   bytes_taken  = 0;
	int   errors       = 0;
	int   send_gap     = 0;
	int   recv_stall   = 0;
	logic quiet        = 1'b0;
	logic long_hold    = 1'b0;

	function automatic logic is_control(logic [BYTE_W-1:0] b);
		return (b < CH_SPACE || b[BYTE_W-1]) && b != CH_CR;
	endfunction

	function automatic int bump_count(int n);
		return (n < ARGS_MAX) ? n + 1 : ARGS_MAX;
	endfunction

	task automatic tokenize_byte(input logic [BYTE_W-1:0] b);
		token_beat_t r;
		int          n;
		r = '0;
		if (is_control(b))
			return;
		r.echo_byte = b;
		if (line_fill >= LINE_BYTES - 1 || b == CH_CR) begin
			// The byte that closes the line is replaced by the terminator.
			n = word_count;
			if (parse_mode == PS_WORD)
				n = bump_count(n);
			r.store_valid = 1'b1;
			r.store_pos   = POS_W'(line_fill);
			r.store_byte  = CH_NUL;
			r.line_end    = 1'b1;
			r.line_full   = (line_fill >= LINE_BYTES - 1);
			r.arg_count   = INDEX_W'(n);
			r.line_length = POS_W'(line_fill);
			parse_mode = PS_IDLE;
			word_count = 0;
			line_fill  = 0;
		end else if (parse_mode == PS_WORD) begin
			if (b == CH_SPACE) begin
				parse_mode = PS_GAP;
				word_count = bump_count(word_count);
			end
			r.store_valid = 1'b1;
			r.store_pos   = POS_W'(line_fill);
			r.store_byte  = b;
			line_fill++;
		end else if (b != CH_SPACE) begin
			r.token_start = 1'b1;
			r.arg_index   = INDEX_W'(word_count);
			parse_mode    = PS_WORD;
			r.store_valid = 1'b1;
			r.store_pos   = POS_W'(line_fill);
			r.store_byte  = b;
			line_fill++;
		end
		pending_results.push_back(r);
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic add_byte(input logic [BYTE_W-1:0] b);
		rx_bytes.push_back(b);
		if (!is_control(b))
			items_queued++;
	endtask

	// One line of words; with overrun set, words go on until the store is full.
	task automatic add_line(input bit overrun);
		int words;
		int wl;
		int fill;
		int i;
		int k;
		fill = 0;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) add_byte(CH_SPACE);
		if (overrun)
			words = 1000;
		else if ($urandom_range(0, 9) == 0)
			words = $urandom_range(12, 22);
		else
			words = $urandom_range(0, 5);
		for (i = 0; i < words && fill < LINE_BYTES - 1; i++) begin
			wl = $urandom_range(1, 6);
			for (k = 0; k < wl && fill < LINE_BYTES - 1; k++) begin
				if ($urandom_range(0, 19) == 0)
					add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 12))
						: 8'($urandom_range(128, 255)));
				add_byte(8'($urandom_range(33, 126)));
				fill++;
			end
			if (fill < LINE_BYTES - 1 && (i < words - 1 || $urandom_range(0, 3) == 0)) begin
				add_byte(CH_SPACE);
				fill++;
				repeat ($urandom_range(0, 2)) add_byte(CH_SPACE);
			end
		end
		if (overrun && $urandom_range(0, 1))
			add_byte(8'($urandom_range(32, 126)));
		else
			add_byte(CH_CR);
	endtask

	task automatic add_random(input int target);
		int first;
		int r;
		first = items_queued;
		while (items_queued - first < target) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
			else if (r < 16)
				add_line(1'b1);
			else
				add_line(1'b0);
		end
	endtask

	task automatic wait_drained();
		while (rx_bytes.size() != 0 || console_ch.valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Sender: one beat per cycle at most, with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			console_ch.valid   <= 1'b0;
			console_ch.rx_byte <= '0;
			send_gap           <= 0;
		end else begin
			if (console_ch.valid && console_ch.ready) begin
				tokenize_byte(console_ch.rx_byte);
				bytes_taken <= bytes_taken + 1;
			end
			if (!console_ch.valid || console_ch.ready) begin
				if (send_gap != 0) begin
					send_gap         <= send_gap - 1;
					console_ch.valid <= 1'b0;
				end else if (rx_bytes.size() != 0 && (quiet || $urandom_range(0, 9) != 0)) begin
					console_ch.valid   <= 1'b1;
					console_ch.rx_byte <= rx_bytes.pop_front();
				end else begin
					if (rx_bytes.size() != 0)
						send_gap <= $urandom_range(0, 5);
					console_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready with random stall bursts and one long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_ch.ready <= 1'b0;
			recv_stall     <= 0;
		end else if (long_hold) begin
			token_ch.ready <= 1'b0;
		end else if (recv_stall != 0) begin
			recv_stall     <= recv_stall - 1;
			token_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			recv_stall     <= $urandom_range(0, 5);
			token_ch.ready <= 1'b0;
		end else begin
			token_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		token_beat_t want;
		if (arst_n && token_ch.valid && token_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, echo %0h", token_ch.echo_byte));
			end else begin
				want = pending_results.pop_front();
				check_field("echo_byte", token_ch.echo_byte, want.echo_byte);
				check_field("store_valid", BYTE_W'(token_ch.store_valid),
					BYTE_W'(want.store_valid));
				check_field("store_pos", BYTE_W'(token_ch.store_pos), BYTE_W'(want.store_pos));
				check_field("store_byte", token_ch.store_byte, want.store_byte);
				check_field("token_start", BYTE_W'(token_ch.token_start),
					BYTE_W'(want.token_start));
				check_field("arg_index", BYTE_W'(token_ch.arg_index), BYTE_W'(want.arg_index));
				check_field("line_end", BYTE_W'(token_ch.line_end), BYTE_W'(want.line_end));
				check_field("line_full", BYTE_W'(token_ch.line_full), BYTE_W'(want.line_full));
				check_field("arg_count", BYTE_W'(token_ch.arg_count), BYTE_W'(want.arg_count));
				check_field("line_length", BYTE_W'(token_ch.line_length),
					BYTE_W'(want.line_length));
			end
		end
	end

	// Long receiver hold while the sender keeps offering, so the input backs up.
	initial begin
		@(posedge arst_n);
		while (bytes_taken < 150)
			@(negedge clk);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (120) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#1000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Control bytes at both ends of the range, an empty line, idle spaces,
		// a space that ends a word, a skipped gap, printable extremes, a trailing space.
		add_byte(8'h00);
		add_byte(8'h1F);
		add_byte(8'h80);
		add_byte(8'hFF);
		add_byte(CH_CR);
		add_byte(CH_SPACE);
		add_byte(CH_SPACE);
		add_byte("a");
		add_byte("b");
		add_byte(CH_SPACE);
		add_byte(CH_SPACE);
		add_byte(8'h21);
		add_byte(8'h7F);
		add_byte(CH_SPACE);
		add_byte(CH_CR);
		add_byte(CH_SPACE);
		add_byte("x");
		add_byte(CH_CR);
		wait_drained();

		add_random(500);
		wait_drained();

		add_random(450);
		wait_drained();

		quiet = 1'b1;
		add_random(250);
		wait_drained();

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
